[design/fp32_add_sub_mul_div_truncating_defines.svh]
// assertion macros used by the checker
`ifndef FP32_ADD_SUB_MUL_DIV_TRUNCATING_DEFINES_SVH
`define FP32_ADD_SUB_MUL_DIV_TRUNCATING_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FPU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define FPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fpu_pkg.sv]
package fpu_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;

    localparam logic [31:0] QNAN_WORD = 32'h7FC0_0000;
    localparam logic [31:0] INF_WORD  = 32'h7F80_0000;
    localparam int          EXP_BIAS  = 127;
    localparam int          MIN_DEN_EXP = -22;
    localparam int          EXP_MAX   = 255;

    localparam int FL_INVALID = 0;
    localparam int FL_OVERFLOW = 1;
    localparam int FL_UNDERFL = 2;
    localparam int FL_DIVZERO = 3;
    localparam int FL_INEXACT = 4;

    localparam int QUEUE_DEPTH = 4;

    // front-end classification kinds
    localparam logic [1:0] K_FIXED = 2'd0;
    localparam logic [1:0] K_ADD   = 2'd1;
    localparam logic [1:0] K_MUL   = 2'd2;
    localparam logic [1:0] K_DIV   = 2'd3;

    // exponent range handled internally (signed, 11 bits)
    typedef logic signed [10:0] exp_t;

    // classified operation moving from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fixed_word;
        logic [4:0]  fixed_flags;
        logic        sign_a;
        logic        sign_b;
        exp_t        exp_a;
        exp_t        exp_b;
        logic [23:0] mant_a;
        logic [23:0] mant_b;
        logic [4:0]  tag;
    } fpu_op_t;

    // leading zero count of a 24-bit value (24 when zero)
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[design/fpu_front.sv]
// unpacks and classifies one operation per cycle while its output is not stalled
module fpu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_req_type,
    input  logic [31:0]          s_operand_a,
    input  logic [31:0]          s_operand_b,
    input  logic [4:0]           s_dest_tag,
    output logic                 op_valid,
    input  logic                 op_ready,
    output fpu_pkg::fpu_op_t     op_data
);

    logic             valid_reg;
    fpu_pkg::fpu_op_t data_reg;
    fpu_pkg::fpu_op_t data_next;

    logic        sa, sb, sbe;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        za, zb, ia, ib, na, nb, da, db;
    logic [4:0]  lza, lzb;

    assign s_ready  = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op_data  = data_reg;

    // field decode
    always_comb begin
        sa = s_operand_a[31];
        sb = s_operand_b[31];
        ea = s_operand_a[30:23];
        eb = s_operand_b[30:23];
        fa = s_operand_a[22:0];
        fb = s_operand_b[22:0];
        za = (ea == 8'd0) && (fa == 23'd0);
        zb = (eb == 8'd0) && (fb == 23'd0);
        ia = (ea == 8'hFF) && (fa == 23'd0);
        ib = (eb == 8'hFF) && (fb == 23'd0);
        na = (ea == 8'hFF) && (fa != 23'd0);
        nb = (eb == 8'hFF) && (fb != 23'd0);
        da = (ea == 8'd0) && (fa != 23'd0);
        db = (eb == 8'd0) && (fb != 23'd0);
        sbe = sb ^ (s_req_type == fpu_pkg::OP_SUB);
        lza = fpu_pkg::lzc24({1'b0, fa});
        lzb = fpu_pkg::lzc24({1'b0, fb});
    end

    // special cases and operand preparation
    always_comb begin
        data_next             = '0;
        data_next.tag         = s_dest_tag;
        data_next.kind        = fpu_pkg::K_FIXED;
        data_next.sign_a      = sa;
        data_next.sign_b      = sb;
        unique case (s_req_type)
            fpu_pkg::OP_ADD, fpu_pkg::OP_SUB: begin
                data_next.sign_b = sbe;
                if (na || nb) begin
                    data_next.fixed_word = fpu_pkg::QNAN_WORD;
                    data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
                end else if (ia || ib) begin
                    if (ia && ib && (sa != sbe)) begin
                        data_next.fixed_word = fpu_pkg::QNAN_WORD;
                        data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
                    end else begin
                        data_next.fixed_word = {ia ? sa : sbe, fpu_pkg::INF_WORD[30:0]};
                    end
                end else if (za && zb) begin
                    data_next.fixed_word = {sa & sbe, 31'd0};
                end else if (za) begin
                    data_next.fixed_word = {sbe, s_operand_b[30:0]};
                end else if (zb) begin
                    data_next.fixed_word = s_operand_a;
                end else begin
                    data_next.kind   = fpu_pkg::K_ADD;
                    data_next.exp_a  = da ? 11'sd1 : fpu_pkg::exp_t'({3'd0, ea});
                    data_next.exp_b  = db ? 11'sd1 : fpu_pkg::exp_t'({3'd0, eb});
                    data_next.mant_a = {~da, fa};
                    data_next.mant_b = {~db, fb};
                end
            end
            fpu_pkg::OP_MUL: begin
                if (na || nb || (ia && zb) || (za && ib)) begin
                    data_next.fixed_word = fpu_pkg::QNAN_WORD;
                    data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
                end else if (ia || ib) begin
                    data_next.fixed_word = {sa ^ sb, fpu_pkg::INF_WORD[30:0]};
                end else if (za || zb) begin
                    data_next.fixed_word = {sa ^ sb, 31'd0};
                end else begin
                    data_next.kind = fpu_pkg::K_MUL;
                end
            end
            fpu_pkg::OP_DIV: begin
                if (na || nb) begin
                    data_next.fixed_word = fpu_pkg::QNAN_WORD;
                    data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
                end else if (zb) begin
                    data_next.fixed_flags[fpu_pkg::FL_DIVZERO] = 1'b1;
                    if (za) begin
                        data_next.fixed_word = fpu_pkg::QNAN_WORD;
                        data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
                    end else begin
                        data_next.fixed_word = {sa ^ sb, fpu_pkg::INF_WORD[30:0]};
                    end
                end else if (za) begin
                    data_next.fixed_word = {sa ^ sb, 31'd0};
                end else if (ia) begin
                    if (ib) begin
                        data_next.fixed_word = fpu_pkg::QNAN_WORD;
                        data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
                    end else begin
                        data_next.fixed_word = {sa ^ sb, fpu_pkg::INF_WORD[30:0]};
                    end
                end else if (ib) begin
                    data_next.fixed_word = {sa ^ sb, 31'd0};
                end else begin
                    data_next.kind = fpu_pkg::K_DIV;
                end
            end
            default: begin
                data_next.fixed_word = fpu_pkg::QNAN_WORD;
                data_next.fixed_flags[fpu_pkg::FL_INVALID] = 1'b1;
            end
        endcase
        // normalized operands for multiply and divide
        if ((data_next.kind == fpu_pkg::K_MUL) || (data_next.kind == fpu_pkg::K_DIV)) begin
            data_next.exp_a  = da ? (11'sd1 - fpu_pkg::exp_t'({6'd0, lza}))
                                  : fpu_pkg::exp_t'({3'd0, ea});
            data_next.exp_b  = db ? (11'sd1 - fpu_pkg::exp_t'({6'd0, lzb}))
                                  : fpu_pkg::exp_t'({3'd0, eb});
            data_next.mant_a = da ? ({1'b0, fa} << lza) : {1'b1, fa};
            data_next.mant_b = db ? ({1'b0, fb} << lzb) : {1'b1, fb};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[design/fpu_queue.sv]
// small fifo between front and back
module fpu_queue #(
    parameter int DEPTH = fpu_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpu_pkg::fpu_op_t in_data,
    output logic             deq_valid,
    input  logic             out_ready,
    output fpu_pkg::fpu_op_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fpu_pkg::fpu_op_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign deq_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = deq_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule

[design/fpu_back.sv]
// arithmetic pipeline: align/multiply/divide stages, then normalize and pack
module fpu_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             op_valid,
    output logic             op_ready,
    input  fpu_pkg::fpu_op_t op_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_result_word,
    output logic [4:0]       m_flags,
    output logic [4:0]       m_tag_out
);

    localparam int NDIV = 24;
    localparam int NST  = NDIV + 3;

    // pipeline stage contents
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fixed_word;
        logic [4:0]  fixed_flags;
        logic        sign;
        logic        sign_b;
        fpu_pkg::exp_t exp;
        logic [24:0] ma;
        logic [24:0] mb;
        logic [23:0] quo;
        logic [4:0]  tag;
    } stage_t;

    logic   adv;
    logic   v_reg [NST];
    stage_t s_reg [NST];
    stage_t s_next [NST];
    logic [47:0] prod_reg;
    logic [47:0] prod_next;

    assign adv      = !m_valid || m_ready;
    assign op_ready = adv;

    // stage 0: addition alignment, product, division setup
    always_comb begin
        logic [10:0] d;
        s_next[0]             = '0;
        s_next[0].kind        = op_data.kind;
        s_next[0].fixed_word  = op_data.fixed_word;
        s_next[0].fixed_flags = op_data.fixed_flags;
        s_next[0].tag         = op_data.tag;
        s_next[0].sign        = op_data.sign_a;
        s_next[0].sign_b      = op_data.sign_b;
        prod_next             = op_data.mant_a * op_data.mant_b;
        d = op_data.exp_a - op_data.exp_b;
        unique case (op_data.kind)
            fpu_pkg::K_ADD: begin
                if (!d[10]) begin
                    s_next[0].exp = op_data.exp_a;
                    s_next[0].ma  = {1'b0, op_data.mant_a};
                    s_next[0].mb  = (d >= 11'd24) ? '0 : ({1'b0, op_data.mant_b} >> d[4:0]);
                end else begin
                    s_next[0].exp = op_data.exp_b;
                    s_next[0].mb  = {1'b0, op_data.mant_b};
                    s_next[0].ma  = ((-d) >= 11'd24) ? '0
                                  : ({1'b0, op_data.mant_a} >> 5'(-d));
                end
            end
            fpu_pkg::K_MUL: begin
                s_next[0].sign = op_data.sign_a ^ op_data.sign_b;
                s_next[0].exp  = op_data.exp_a + op_data.exp_b
                               - 11'(fpu_pkg::EXP_BIAS);
            end
            fpu_pkg::K_DIV: begin
                s_next[0].sign = op_data.sign_a ^ op_data.sign_b;
                s_next[0].exp  = op_data.exp_a - op_data.exp_b
                               + 11'(fpu_pkg::EXP_BIAS);
                s_next[0].ma   = {1'b0, op_data.mant_a};
                s_next[0].mb   = {1'b0, op_data.mant_b};
            end
            default: begin
                s_next[0].exp = '0;
            end
        endcase
    end

    // stage 1: add/subtract magnitudes, take product bits
    always_comb begin
        s_next[1] = s_reg[0];
        unique case (s_reg[0].kind)
            fpu_pkg::K_ADD: begin
                if (s_reg[0].sign == s_reg[0].sign_b) begin
                    s_next[1].ma = s_reg[0].ma + s_reg[0].mb;
                end else if (s_reg[0].ma >= s_reg[0].mb) begin
                    s_next[1].ma = s_reg[0].ma - s_reg[0].mb;
                end else begin
                    s_next[1].ma   = s_reg[0].mb - s_reg[0].ma;
                    s_next[1].sign = s_reg[0].sign_b;
                end
            end
            fpu_pkg::K_MUL: begin
                if (prod_reg[47]) begin
                    s_next[1].ma  = {1'b0, prod_reg[47:24]};
                    s_next[1].exp = s_reg[0].exp + 11'sd1;
                end else begin
                    s_next[1].ma  = {1'b0, prod_reg[46:23]};
                end
            end
            default: begin
                s_next[1].exp = s_reg[0].exp;
            end
        endcase
    end

    // restoring division: one quotient bit per stage, remainder in ma
    for (genvar k = 2; k < NDIV + 2; k++) begin : g_div
        always_comb begin
            logic [24:0] rem;
            rem = s_reg[k-1].ma;
            s_next[k] = s_reg[k-1];
            if (s_reg[k-1].kind == fpu_pkg::K_DIV) begin
                if (rem >= s_reg[k-1].mb) begin
                    rem = rem - s_reg[k-1].mb;
                    s_next[k].quo = {s_reg[k-1].quo[22:0], 1'b1};
                end else begin
                    s_next[k].quo = {s_reg[k-1].quo[22:0], 1'b0};
                end
                s_next[k].ma = {rem[23:0], 1'b0};
            end
        end
    end

    // last stage: normalize and pack
    always_comb begin
        stage_t      t;
        logic [23:0] m;
        fpu_pkg::exp_t ex, sh;
        logic [4:0]  lz;
        logic [31:0] w;
        logic [4:0]  fl;
        t  = s_reg[NST-2];
        w  = t.fixed_word;
        fl = t.fixed_flags;
        ex = t.exp;
        m  = t.ma[23:0];
        lz = '0;
        sh = '0;
        if (t.kind == fpu_pkg::K_DIV) begin
            m = t.quo;
        end
        if ((t.kind == fpu_pkg::K_ADD) && t.ma[24]) begin
            m  = t.ma[24:1];
            ex = t.exp + 11'sd1;
        end
        s_next[NST-1] = t;
        if ((t.kind == fpu_pkg::K_ADD) && (t.ma == '0)) begin
            w = '0;
        end else if (t.kind != fpu_pkg::K_FIXED) begin
            lz = fpu_pkg::lzc24(m);
            // shift left while above exponent one
            if ((m != '0) && (ex > 11'sd1)) begin
                sh = fpu_pkg::exp_t'({6'd0, lz});
                if (sh > ex - 11'sd1) begin
                    sh = ex - 11'sd1;
                end
                m  = m << sh[4:0];
                ex = ex - sh;
            end
            if (ex >= fpu_pkg::exp_t'(fpu_pkg::EXP_MAX)) begin
                fl[fpu_pkg::FL_OVERFLOW] = 1'b1;
                w = {t.sign, fpu_pkg::INF_WORD[30:0]};
            end else if (ex <= 11'sd0) begin
                fl[fpu_pkg::FL_UNDERFL] = 1'b1;
                if ((ex >= fpu_pkg::exp_t'(fpu_pkg::MIN_DEN_EXP)) && (m != '0)) begin
                    w = {t.sign, 8'd0, 23'(m >> 5'(11'sd1 - ex))};
                end else begin
                    w = {t.sign, 31'd0};
                end
            end else if (!m[23]) begin
                fl[fpu_pkg::FL_UNDERFL] = 1'b1;
                w = {t.sign, 8'd0, m[22:0]};
            end else begin
                w = {t.sign, ex[7:0], m[22:0]};
            end
        end
        s_next[NST-1].fixed_word  = w;
        s_next[NST-1].fixed_flags = fl;
    end

    // stage registers, all advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= op_valid;
            for (int k = 1; k < NST; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                s_reg[k] <= s_next[k];
            end
            prod_reg <= prod_next;
        end
    end

    assign m_valid       = v_reg[NST-1];
    assign m_result_word = s_reg[NST-1].fixed_word;
    assign m_flags       = s_reg[NST-1].fixed_flags;
    assign m_tag_out     = s_reg[NST-1].tag;

endmodule

[design/fp32_add_sub_mul_div_truncating.sv]
// Single-precision add, subtract, multiply and divide with truncation (no
// rounding, inexact never set). A front stage decodes operands and resolves
// NaN, infinity and zero cases; a four-entry queue feeds a fixed 27-stage
// back pipeline (alignment/multiply, add, 24 restoring division stages, then
// normalize and pack). One beat is accepted per cycle while the queue has room;
// every operation passes through the front register, the queue and every back
// stage, and results leave in order. A stalled result freezes the whole back
// pipeline; the queue and front register then absorb input until full.
module fp32_add_sub_mul_div_truncating #(
    parameter int QUEUE_DEPTH = fpu_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_req_type,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    input  logic [4:0]  s_dest_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_word,
    output logic [4:0]  m_flags,
    output logic [4:0]  m_tag_out
);

    logic             f_valid, f_ready, q_valid, q_ready;
    fpu_pkg::fpu_op_t f_data, q_data;

    fpu_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_operand_a,
        .s_operand_b, .s_dest_tag,
        .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
    );

    fpu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .deq_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    fpu_back u_back (
        .aclk, .aresetn,
        .op_valid(q_valid), .op_ready(q_ready), .op_data(q_data),
        .m_valid, .m_ready, .m_result_word, .m_flags, .m_tag_out
    );

endmodule

[design/fpu_checker.sv]
`include "fp32_add_sub_mul_div_truncating_defines.svh"

// port-level checks on the result channel
module fpu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_result_word,
    input logic [4:0]  m_flags
);

    `FPU_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_word), "result changed while stalled")
    `FPU_ASSERT_IMPL(a_inexact, aclk, aresetn, m_valid, !m_flags[fpu_pkg::FL_INEXACT], "inexact flag raised")
    `FPU_ASSERT_IMPL(a_invalid_nan, aclk, aresetn, m_valid && m_flags[fpu_pkg::FL_INVALID], m_result_word == fpu_pkg::QNAN_WORD, "invalid without canonical nan")
    `FPU_ASSERT_IMPL(a_ovf_inf, aclk, aresetn, m_valid && m_flags[fpu_pkg::FL_OVERFLOW], m_result_word[30:0] == fpu_pkg::INF_WORD[30:0], "overflow without infinity")

endmodule

bind fp32_add_sub_mul_div_truncating fpu_checker u_fpu_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_result_word, .m_flags
);
